### hw/rtl/lps_pkg.sv
package lps_pkg;

   // Sizes of the pattern store.
   localparam int STRIPS   = 4;
   localparam int BULBS    = 8;
   localparam int STEPS    = 8;
   localparam int PATTERNS = 16;

   // Field widths of the input and result words.
   localparam int CMD_W      = 2;
   localparam int TIME_W     = 32;
   localparam int MODE_W     = 8;
   localparam int PATTERN_W  = 4;
   localparam int STRIP_W    = 2;
   localparam int STEP_W     = 3;
   localparam int BULB_W     = 3;
   localparam int COLOR_W    = 24;
   localparam int DURATION_W = 16;
   localparam int COUNT_W    = 4;

   // Table depths and address widths.
   localparam int COUNT_DEPTH = PATTERNS * STRIPS;
   localparam int DUR_DEPTH   = COUNT_DEPTH * STEPS;
   localparam int COLOR_DEPTH = DUR_DEPTH * BULBS;
   localparam int COUNT_AW    = $clog2(COUNT_DEPTH);
   localparam int DUR_AW      = $clog2(DUR_DEPTH);
   localparam int COLOR_AW    = $clog2(COLOR_DEPTH);

   // Flight modes that select a pattern when armed, and the patterns they select.
   localparam logic [MODE_W-1:0]    MODE_A        = 8'd2;
   localparam logic [MODE_W-1:0]    MODE_B        = 8'd8;
   localparam logic [MODE_W-1:0]    MODE_C        = 8'd9;
   localparam logic [MODE_W-1:0]    MODE_D        = 8'd10;
   localparam logic [MODE_W-1:0]    MODE_E        = 8'd13;
   localparam logic [MODE_W-1:0]    MODE_F        = 8'd12;
   localparam logic [PATTERN_W-1:0] PAT_UNARMED   = 4'd2;
   localparam logic [PATTERN_W-1:0] PAT_MODE_A    = 4'd4;
   localparam logic [PATTERN_W-1:0] PAT_MODE_B    = 4'd7;
   localparam logic [PATTERN_W-1:0] PAT_MODE_C    = 4'd8;
   localparam logic [PATTERN_W-1:0] PAT_MODE_D    = 4'd9;
   localparam logic [PATTERN_W-1:0] PAT_MODE_E    = 4'd6;
   localparam logic [PATTERN_W-1:0] PAT_MODE_F    = 4'd5;
   localparam logic [PATTERN_W-1:0] PAT_DEFAULT   = 4'd0;

   typedef enum logic [CMD_W-1:0] {
      CMD_TICK     = 2'd0,
      CMD_COLOR    = 2'd1,
      CMD_DURATION = 2'd2,
      CMD_COUNT    = 2'd3
   } command_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DECODE,
      ST_SCAN_RD,
      ST_SCAN_CHK,
      ST_STRIP,
      ST_DUR,
      ST_BULB
   } state_type;

   typedef struct packed {
      command_type             command;
      logic [TIME_W-1:0]       now_ms;
      logic                    armed;
      logic [MODE_W-1:0]       flight_mode;
      logic [PATTERN_W-1:0]    table_pattern;
      logic [STRIP_W-1:0]      table_strip;
      logic [STEP_W-1:0]       table_step;
      logic [BULB_W-1:0]       table_bulb;
      logic [COLOR_W-1:0]      table_color;
      logic [DURATION_W-1:0]   table_duration;
      logic [COUNT_W-1:0]      table_count;
   } req_word_type;

   typedef struct packed {
      logic [STRIP_W-1:0] strip_index;
      logic [BULB_W-1:0]  bulb_index;
      logic [COLOR_W-1:0] bulb_color;
      logic               last;
   } rsp_word_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic load;
      logic do_write;
      logic strip_clear;
      logic strip_next;
      logic scan_rd;
      logic scan_chk;
      logic strip_step;
      logic dur_load;
      logic issue;
   } ctrl_cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic is_tick;
      logic strip_last;
      logic strip_present;
      logic bulb_done;
   } dp_status_type;

endpackage

### hw/rtl/lps_ifs.sv
// Input channel: one word per tick or table write.
interface lps_req_if import lps_pkg::*; ();
   logic                  valid;
   logic                  ready;
   logic [CMD_W-1:0]      command;
   logic [TIME_W-1:0]     now_ms;
   logic                  armed;
   logic [MODE_W-1:0]     flight_mode;
   logic [PATTERN_W-1:0]  table_pattern;
   logic [STRIP_W-1:0]    table_strip;
   logic [STEP_W-1:0]     table_step;
   logic [BULB_W-1:0]     table_bulb;
   logic [COLOR_W-1:0]    table_color;
   logic [DURATION_W-1:0] table_duration;
   logic [COUNT_W-1:0]    table_count;

   modport source (
      output valid, command, now_ms, armed, flight_mode, table_pattern, table_strip,
             table_step, table_bulb, table_color, table_duration, table_count,
      input  ready
   );
   modport sink (
      input  valid, command, now_ms, armed, flight_mode, table_pattern, table_strip,
             table_step, table_bulb, table_color, table_duration, table_count,
      output ready
   );
endinterface

// Result channel: one word per bulb update.
interface lps_rsp_if import lps_pkg::*; ();
   logic               valid;
   logic               ready;
   logic [STRIP_W-1:0] strip_index;
   logic [BULB_W-1:0]  bulb_index;
   logic [COLOR_W-1:0] bulb_color;
   logic               last;

   modport source (
      output valid, strip_index, bulb_index, bulb_color, last,
      input  ready
   );
   modport sink (
      input  valid, strip_index, bulb_index, bulb_color, last,
      output ready
   );
endinterface

### hw/rtl/lps_ram.sv
module lps_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // One write port and one registered read port; read data holds while idle.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

### hw/rtl/lps_ctrl.sv
module lps_ctrl import lps_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  logic          req_valid,
   output logic          req_ready,
   input  dp_status_type status,
   output ctrl_cmd_type  cmd,
   output state_type     state
);

   state_type state_ff;
   state_type state_in;

   // Next state.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               state_in = ST_DECODE;
            end
         end
         ST_DECODE: begin
            state_in = status.is_tick ? ST_SCAN_RD : ST_IDLE;
         end
         ST_SCAN_RD: begin
            state_in = ST_SCAN_CHK;
         end
         ST_SCAN_CHK: begin
            state_in = status.strip_last ? ST_STRIP : ST_SCAN_RD;
         end
         ST_STRIP: begin
            if (status.strip_present) begin
               state_in = ST_DUR;
            end else if (status.strip_last) begin
               state_in = ST_IDLE;
            end
         end
         ST_DUR: begin
            state_in = ST_BULB;
         end
         ST_BULB: begin
            if (status.bulb_done) begin
               state_in = status.strip_last ? ST_IDLE : ST_STRIP;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Outputs: commands to the datapath. No word is taken while reset is held.
   always_comb begin
      cmd       = '0;
      req_ready = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_ready = !reset;
            cmd.load  = req_valid && !reset;
         end
         ST_DECODE: begin
            cmd.do_write    = !status.is_tick;
            cmd.strip_clear = status.is_tick;
         end
         ST_SCAN_RD: begin
            cmd.scan_rd = 1'b1;
         end
         ST_SCAN_CHK: begin
            cmd.scan_chk    = 1'b1;
            cmd.strip_clear = status.strip_last;
            cmd.strip_next  = !status.strip_last;
         end
         ST_STRIP: begin
            cmd.strip_step = status.strip_present;
            cmd.strip_next = !status.strip_present && !status.strip_last;
         end
         ST_DUR: begin
            cmd.dur_load = 1'b1;
         end
         ST_BULB: begin
            cmd.issue      = 1'b1;
            cmd.strip_next = status.bulb_done && !status.strip_last;
         end
         default: begin
            cmd = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign state = state_ff;

endmodule

### hw/rtl/lps_dp.sv
module lps_dp import lps_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  req_word_type  req_word,
   input  ctrl_cmd_type  cmd,
   output dp_status_type status,
   input  logic          rsp_ready,
   output logic          rsp_valid,
   output rsp_word_type  rsp_word
);

   // Pattern chosen by the armed flag and flight mode.
   function automatic logic [PATTERN_W-1:0] pick_pattern(input logic armed,
                                                         input logic [MODE_W-1:0] mode);
      logic [PATTERN_W-1:0] pat;
      pat = PAT_DEFAULT;
      if (!armed) begin
         pat = PAT_UNARMED;
      end else begin
         case (mode)
            MODE_A:  pat = PAT_MODE_A;
            MODE_B:  pat = PAT_MODE_B;
            MODE_C:  pat = PAT_MODE_C;
            MODE_D:  pat = PAT_MODE_D;
            MODE_E:  pat = PAT_MODE_E;
            MODE_F:  pat = PAT_MODE_F;
            default: pat = PAT_DEFAULT;
         endcase
      end
      return pat;
   endfunction

   // (step + 1) mod count by repeated subtraction; count is at least one.
   function automatic logic [STEP_W-1:0] step_advance(input logic [STEP_W-1:0] step,
                                                      input logic [COUNT_W-1:0] count);
      logic [COUNT_W:0] acc;
      acc = (COUNT_W + 1)'(step) + 1'b1;
      for (int i = 0; i < STEPS; i++) begin
         if (acc >= (COUNT_W + 1)'(count)) begin
            acc = acc - (COUNT_W + 1)'(count);
         end
      end
      return acc[STEP_W-1:0];
   endfunction

   function automatic logic [COUNT_AW-1:0] count_addr(input logic [PATTERN_W-1:0] p,
                                                      input logic [STRIP_W-1:0] s);
      return COUNT_AW'(int'(p) * STRIPS + int'(s));
   endfunction

   function automatic logic [DUR_AW-1:0] dur_addr(input logic [PATTERN_W-1:0] p,
                                                  input logic [STRIP_W-1:0] s,
                                                  input logic [STEP_W-1:0] st);
      return DUR_AW'((int'(p) * STRIPS + int'(s)) * STEPS + int'(st));
   endfunction

   function automatic logic [COLOR_AW-1:0] color_addr(input logic [PATTERN_W-1:0] p,
                                                      input logic [STRIP_W-1:0] s,
                                                      input logic [STEP_W-1:0] st,
                                                      input logic [BULB_W-1:0] b);
      return COLOR_AW'(((int'(p) * STRIPS + int'(s)) * STEPS + int'(st)) * BULBS + int'(b));
   endfunction

   req_word_type          word_ff, word_in;
   logic [STRIP_W-1:0]    strip_ff, strip_in;
   logic [BULB_W-1:0]     bulb_ff, bulb_in;
   logic [STEP_W-1:0]     step_ff [STRIPS];
   logic [STEP_W-1:0]     step_in [STRIPS];
   logic [TIME_W-1:0]     expiry_ff [STRIPS];
   logic [TIME_W-1:0]     expiry_in [STRIPS];
   logic [COUNT_W-1:0]    cnt_ff [STRIPS];
   logic [COUNT_W-1:0]    cnt_in [STRIPS];
   logic [STRIPS-1:0]     present_ff, present_in;
   logic [COUNT_DEPTH-1:0] cvalid_ff, cvalid_in;
   logic                  cvalid_rd_ff, cvalid_rd_in;
   logic                  s1_valid_ff, s1_valid_in;
   logic [STRIP_W-1:0]    s1_strip_ff, s1_strip_in;
   logic [BULB_W-1:0]     s1_bulb_ff, s1_bulb_in;
   logic                  s1_last_ff, s1_last_in;
   logic                  out_valid_ff, out_valid_in;
   rsp_word_type          out_word_ff, out_word_in;

   logic [PATTERN_W-1:0]  sel_pattern;
   logic                  wr_pattern_ok;
   logic                  wr_strip_ok;
   logic                  wr_step_ok;
   logic                  wr_bulb_ok;
   logic                  count_wr;
   logic                  dur_wr;
   logic                  color_wr;
   logic [COUNT_W-1:0]    count_wr_data;
   logic [COUNT_AW-1:0]   count_wr_addr;
   logic [COUNT_AW-1:0]   count_rd_addr;
   logic [COUNT_W-1:0]    count_rd_data;
   logic [COUNT_W-1:0]    count_seen;
   logic [STEP_W-1:0]     next_step;
   logic [DURATION_W-1:0] dur_rd_data;
   logic [COLOR_W-1:0]    color_rd_data;
   logic                  advance;
   logic                  issue_now;
   logic                  bulb_final;
   logic                  no_higher;

   // Decode of the captured word.
   assign sel_pattern   = pick_pattern(word_ff.armed, word_ff.flight_mode);
   assign wr_pattern_ok = int'(word_ff.table_pattern) < PATTERNS;
   assign wr_strip_ok   = int'(word_ff.table_strip) < STRIPS;
   assign wr_step_ok    = int'(word_ff.table_step) < STEPS;
   assign wr_bulb_ok    = int'(word_ff.table_bulb) < BULBS;
   assign count_wr = cmd.do_write && (word_ff.command == CMD_COUNT)
                     && wr_pattern_ok && wr_strip_ok;
   assign dur_wr   = cmd.do_write && (word_ff.command == CMD_DURATION)
                     && wr_pattern_ok && wr_strip_ok && wr_step_ok;
   assign color_wr = cmd.do_write && (word_ff.command == CMD_COLOR)
                     && wr_pattern_ok && wr_strip_ok && wr_step_ok && wr_bulb_ok;
   assign count_wr_data = (int'(word_ff.table_count) > STEPS) ? COUNT_W'(STEPS)
                                                             : word_ff.table_count;
   assign count_wr_addr = count_addr(word_ff.table_pattern, word_ff.table_strip);
   assign count_rd_addr = count_addr(sel_pattern, strip_ff);

   // A count entry never written reads as zero.
   assign count_seen = cvalid_rd_ff ? count_rd_data : '0;
   assign next_step  = step_advance(step_ff[strip_ff], cnt_ff[strip_ff]);

   // Bulb read pipeline: the RAM read register is stage one, the output register stage two.
   assign advance    = !out_valid_ff || rsp_ready;
   assign issue_now  = cmd.issue && advance;
   assign bulb_final = bulb_ff == BULB_W'(BULBS - 1);

   // The last word of a tick belongs to the highest strip that updates.
   always_comb begin
      no_higher = 1'b1;
      for (int i = 0; i < STRIPS; i++) begin
         if ((i > int'(strip_ff)) && present_ff[i]) begin
            no_higher = 1'b0;
         end
      end
   end

   lps_ram #(.WIDTH(COUNT_W), .DEPTH(COUNT_DEPTH)) u_count_ram (
      .clock   (clock),
      .wr_en   (count_wr),
      .wr_addr (count_wr_addr),
      .wr_data (count_wr_data),
      .rd_en   (cmd.scan_rd),
      .rd_addr (count_rd_addr),
      .rd_data (count_rd_data)
   );

   lps_ram #(.WIDTH(DURATION_W), .DEPTH(DUR_DEPTH)) u_dur_ram (
      .clock   (clock),
      .wr_en   (dur_wr),
      .wr_addr (dur_addr(word_ff.table_pattern, word_ff.table_strip, word_ff.table_step)),
      .wr_data (word_ff.table_duration),
      .rd_en   (cmd.strip_step),
      .rd_addr (dur_addr(sel_pattern, strip_ff, next_step)),
      .rd_data (dur_rd_data)
   );

   lps_ram #(.WIDTH(COLOR_W), .DEPTH(COLOR_DEPTH)) u_color_ram (
      .clock   (clock),
      .wr_en   (color_wr),
      .wr_addr (color_addr(word_ff.table_pattern, word_ff.table_strip,
                           word_ff.table_step, word_ff.table_bulb)),
      .wr_data (word_ff.table_color),
      .rd_en   (issue_now),
      .rd_addr (color_addr(sel_pattern, strip_ff, step_ff[strip_ff], bulb_ff)),
      .rd_data (color_rd_data)
   );

   // Next values of the datapath registers.
   always_comb begin
      word_in      = cmd.load ? req_word : word_ff;
      strip_in     = strip_ff;
      bulb_in      = bulb_ff;
      step_in      = step_ff;
      expiry_in    = expiry_ff;
      cnt_in       = cnt_ff;
      present_in   = present_ff;
      cvalid_in    = cvalid_ff;
      cvalid_rd_in = cvalid_rd_ff;
      s1_valid_in  = s1_valid_ff;
      s1_strip_in  = s1_strip_ff;
      s1_bulb_in   = s1_bulb_ff;
      s1_last_in   = s1_last_ff;
      out_valid_in = out_valid_ff;
      out_word_in  = out_word_ff;

      if (cmd.strip_clear) begin
         strip_in = '0;
      end else if (cmd.strip_next) begin
         strip_in = strip_ff + 1'b1;
      end

      if (count_wr) begin
         cvalid_in[count_wr_addr] = 1'b1;
      end
      if (cmd.scan_rd) begin
         cvalid_rd_in = cvalid_ff[count_rd_addr];
      end

      // Scan: note the count and whether the strip is due.
      if (cmd.scan_chk) begin
         cnt_in[strip_ff]     = count_seen;
         present_in[strip_ff] = (count_seen != '0) && (word_ff.now_ms >= expiry_ff[strip_ff]);
      end

      if (cmd.strip_step) begin
         step_in[strip_ff] = next_step;
      end
      if (cmd.dur_load) begin
         expiry_in[strip_ff] = word_ff.now_ms + TIME_W'(dur_rd_data);
         bulb_in             = '0;
      end
      if (issue_now) begin
         bulb_in = bulb_ff + 1'b1;
      end

      if (advance) begin
         s1_valid_in  = issue_now;
         s1_strip_in  = strip_ff;
         s1_bulb_in   = bulb_ff;
         s1_last_in   = bulb_final && no_higher;
         out_valid_in = s1_valid_ff;
         out_word_in.strip_index = s1_strip_ff;
         out_word_in.bulb_index  = s1_bulb_ff;
         out_word_in.bulb_color  = color_rd_data;
         out_word_in.last        = s1_last_ff;
      end
   end

   // Control state and strip state with reset.
   always_ff @(posedge clock) begin
      if (reset) begin
         strip_ff     <= '0;
         cvalid_ff    <= '0;
         s1_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         for (int i = 0; i < STRIPS; i++) begin
            step_ff[i]   <= '0;
            expiry_ff[i] <= '0;
         end
      end else begin
         strip_ff     <= strip_in;
         cvalid_ff    <= cvalid_in;
         s1_valid_ff  <= s1_valid_in;
         out_valid_ff <= out_valid_in;
         step_ff      <= step_in;
         expiry_ff    <= expiry_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      word_ff      <= word_in;
      bulb_ff      <= bulb_in;
      cnt_ff       <= cnt_in;
      present_ff   <= present_in;
      cvalid_rd_ff <= cvalid_rd_in;
      s1_strip_ff  <= s1_strip_in;
      s1_bulb_ff   <= s1_bulb_in;
      s1_last_ff   <= s1_last_in;
      out_word_ff  <= out_word_in;
   end

   assign status.is_tick       = word_ff.command == CMD_TICK;
   assign status.strip_last    = strip_ff == STRIP_W'(STRIPS - 1);
   assign status.strip_present = present_ff[strip_ff];
   assign status.bulb_done     = issue_now && bulb_final;

   assign rsp_valid = out_valid_ff;
   assign rsp_word  = out_word_ff;

endmodule

### hw/rtl/led_pattern_sequencer.sv
// A table write is taken while idle and written in the decode state, then idle resumes.
// A tick reads and checks the count of each strip in turn, then for each strip that updates
// reads the next step's duration and issues its bulbs; a strip that does not is passed over.
// Results pass the RAM read and output registers; one bulb read per cycle unless stalled.
// Synchronous reset clears step indices, expiry times, count valid bits and the handshake;
// color and duration tables are undefined until written.
module led_pattern_sequencer import lps_pkg::*; (
   input logic       clock,
   input logic       reset,
   lps_req_if.sink   req_chan,
   lps_rsp_if.source rsp_chan
);

   ctrl_cmd_type  ctrl_cmd;
   dp_status_type dp_status;
   state_type     ctrl_state;
   req_word_type  req_word;
   rsp_word_type  rsp_word;
   logic          rsp_valid;
   logic          req_ready;

   // Gather the input word.
   always_comb begin
      req_word.command        = command_type'(req_chan.command);
      req_word.now_ms         = req_chan.now_ms;
      req_word.armed          = req_chan.armed;
      req_word.flight_mode    = req_chan.flight_mode;
      req_word.table_pattern  = req_chan.table_pattern;
      req_word.table_strip    = req_chan.table_strip;
      req_word.table_step     = req_chan.table_step;
      req_word.table_bulb     = req_chan.table_bulb;
      req_word.table_color    = req_chan.table_color;
      req_word.table_duration = req_chan.table_duration;
      req_word.table_count    = req_chan.table_count;
   end

   lps_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_ready (req_ready),
      .status    (dp_status),
      .cmd       (ctrl_cmd),
      .state     (ctrl_state)
   );

   lps_dp u_dp (
      .clock     (clock),
      .reset     (reset),
      .req_word  (req_word),
      .cmd       (ctrl_cmd),
      .status    (dp_status),
      .rsp_ready (rsp_chan.ready),
      .rsp_valid (rsp_valid),
      .rsp_word  (rsp_word)
   );

   assign req_chan.ready       = req_ready;
   assign rsp_chan.valid       = rsp_valid;
   assign rsp_chan.strip_index = rsp_word.strip_index;
   assign rsp_chan.bulb_index  = rsp_word.bulb_index;
   assign rsp_chan.bulb_color  = rsp_word.bulb_color;
   assign rsp_chan.last        = rsp_word.last;

   // No result word is offered right after reset.
   a_reset_quiet: assert property (@(posedge clock) reset |=> !rsp_chan.valid)
      else $error("result word offered after reset");

   // A strip only steps when the scan found it due.
   a_step_present: assert property (@(posedge clock) disable iff (reset)
      ctrl_cmd.strip_step |-> dp_status.strip_present)
      else $error("strip stepped without being due");

   // The expiry update always uses a duration read issued the cycle before.
   a_dur_after_step: assert property (@(posedge clock) disable iff (reset)
      ctrl_cmd.dur_load |-> $past(ctrl_cmd.strip_step))
      else $error("expiry loaded without a duration read");

   // Input words are taken only by the idle controller.
   a_accept_idle: assert property (@(posedge clock) disable iff (reset)
      (req_chan.valid && req_chan.ready) |=> (ctrl_state == ST_DECODE))
      else $error("accepted word not decoded");

endmodule

### test/tb.sv
`timescale 1ns / 1ps

module tb;
   import lps_pkg::*;

   localparam int RANDOM_ITEMS = 310;
   localparam int LONG_HOLD    = 400;
   localparam int DRAIN_CYCLES = 100;
   localparam int CYCLE_LIMIT  = 3_000_000;
   localparam int COUNT_MAX    = (1 << COUNT_W) - 1;

   // One row of the opening script: the word to send and whether it must stay silent.
   typedef struct packed {
      req_word_type word;
      logic         quiet;
   } script_row_type;

   // Fields: command, now_ms, armed, flight_mode, pattern, strip, step, bulb,
   // color, duration, count.
   localparam int SCRIPT_ROWS = 22;
   localparam script_row_type SCRIPT [SCRIPT_ROWS] = '{
      '{'{CMD_TICK,     32'h0,         0, 8'h00, 0,  0, 0, 0, 24'h0,      16'h0,    0}, 1},
      '{'{CMD_COLOR,    32'h0,         0, 8'h00, 2,  0, 0, 0, 24'h000000, 16'h0,    0}, 1},
      '{'{CMD_COLOR,    32'h0,         0, 8'h00, 2,  0, 0, 1, 24'hFFFFFF, 16'h0,    0}, 1},
      '{'{CMD_COLOR,    32'h0,         0, 8'h00, 2,  0, 0, 2, 24'hFF0000, 16'h0,    0}, 1},
      '{'{CMD_COLOR,    32'h0,         0, 8'h00, 2,  0, 0, 3, 24'h00FF00, 16'h0,    0}, 1},
      '{'{CMD_COLOR,    32'h0,         0, 8'h00, 2,  0, 0, 4, 24'h0000FF, 16'h0,    0}, 1},
      '{'{CMD_COLOR,    32'h0,         0, 8'h00, 2,  0, 0, 5, 24'h555555, 16'h0,    0}, 1},
      '{'{CMD_COLOR,    32'h0,         0, 8'h00, 2,  0, 0, 6, 24'hAAAAAA, 16'h0,    0}, 1},
      '{'{CMD_COLOR,    32'h0,         0, 8'h00, 2,  0, 0, 7, 24'h123456, 16'h0,    0}, 1},
      '{'{CMD_DURATION, 32'h0,         0, 8'h00, 2,  0, 0, 0, 24'h0,      16'hFFFF, 0}, 1},
      '{'{CMD_COUNT,    32'h0,         0, 8'h00, 2,  0, 0, 0, 24'h0,      16'h0,    1}, 1},
      '{'{CMD_TICK,     32'hFFFFFFF0,  0, 8'hFF, 0,  0, 0, 0, 24'h0,      16'h0,    0}, 0},
      '{'{CMD_TICK,     32'hFFFFFFFF,  0, 8'h00, 0,  0, 0, 0, 24'h0,      16'h0,    0}, 0},
      '{'{CMD_TICK,     32'h10,        1, 8'hFF, 0,  0, 0, 0, 24'h0,      16'h0,    0}, 0},
      '{'{CMD_TICK,     32'h0,         0, 8'h02, 0,  0, 0, 0, 24'h0,      16'h0,    0}, 0},
      '{'{CMD_COUNT,    32'h0,         0, 8'h00, 2,  0, 0, 0, 24'h0,      16'h0,    0}, 1},
      '{'{CMD_TICK,     32'hFFFFFFFF,  0, 8'h00, 0,  0, 0, 0, 24'h0,      16'h0,    0}, 0},
      '{'{CMD_COUNT,    32'h0,         0, 8'h00, 15, 3, 0, 0, 24'h0,      16'h0,   15}, 1},
      '{'{CMD_DURATION, 32'h0,         0, 8'h00, 15, 3, 7, 0, 24'h0,      16'h0,    0}, 1},
      '{'{CMD_COLOR,    32'h0,         0, 8'h00, 15, 3, 7, 7, 24'hFFFFFF, 16'h0,    0}, 1},
      '{'{CMD_COUNT,    32'h0,         0, 8'h00, 2,  0, 0, 0, 24'h0,      16'h0,    1}, 1},
      '{'{CMD_TICK,     32'hFFFFFFFF,  0, 8'h00, 0,  0, 0, 0, 24'h0,      16'h0,    0}, 0}
   };

   // Patterns that some tick can select.
   localparam logic [PATTERN_W-1:0] SHOWN [8] = '{PAT_DEFAULT, PAT_UNARMED, PAT_MODE_A,
      PAT_MODE_B, PAT_MODE_C, PAT_MODE_D, PAT_MODE_E, PAT_MODE_F};

   logic clock = 1'b0;
   logic reset = 1'b1;

   lps_req_if req_chan ();
   lps_rsp_if rsp_chan ();

   led_pattern_sequencer dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan)
   );

   // Mirror of the pattern store and the per-strip animation state.
   logic [COLOR_W-1:0]    lamp_color [COLOR_DEPTH];
   logic                  lamp_known [COLOR_DEPTH];
   logic [DURATION_W-1:0] hold_ms    [DUR_DEPTH];
   logic                  hold_known [DUR_DEPTH];
   logic [COUNT_W-1:0]    step_total [COUNT_DEPTH];
   logic [STEP_W-1:0]     strip_step [STRIPS];
   logic [TIME_W-1:0]     strip_due  [STRIPS];

   rsp_word_type         updates_due [$];
   logic [PATTERN_W-1:0] loaded_pats [$];
   logic [TIME_W-1:0]    wall_ms = '0;

   int   words_checked  = 0;
   int   mismatches     = 0;
   int   cycle_count    = 0;
   int   sent           = 0;
   logic calm           = 1'b0;
   logic long_hold_done = 1'b0;

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   function automatic logic [PATTERN_W-1:0] pattern_for(input logic armed,
                                                        input logic [MODE_W-1:0] mode);
      if (!armed) return PAT_UNARMED;
      case (mode)
         MODE_A:  return PAT_MODE_A;
         MODE_B:  return PAT_MODE_B;
         MODE_C:  return PAT_MODE_C;
         MODE_D:  return PAT_MODE_D;
         MODE_E:  return PAT_MODE_E;
         MODE_F:  return PAT_MODE_F;
         default: return PAT_DEFAULT;
      endcase
   endfunction

   // Sets armed and mode so that a tick selects pattern p.
   function automatic void aim_at(input logic [PATTERN_W-1:0] p, inout req_word_type w);
      w.armed = 1'b1;
      case (p)
         PAT_UNARMED: w.armed = 1'b0;
         PAT_MODE_A:  w.flight_mode = MODE_A;
         PAT_MODE_B:  w.flight_mode = MODE_B;
         PAT_MODE_C:  w.flight_mode = MODE_C;
         PAT_MODE_D:  w.flight_mode = MODE_D;
         PAT_MODE_E:  w.flight_mode = MODE_E;
         PAT_MODE_F:  w.flight_mode = MODE_F;
         default: begin
            while (pattern_for(1'b1, w.flight_mode) != PAT_DEFAULT)
               w.flight_mode = MODE_W'($urandom());
         end
      endcase
   endfunction

   // Number of leading steps of a pattern and strip whose duration and colors are all written.
   function automatic int ready_steps(input int p, input int s);
      int n;
      int row;
      n = 0;
      for (int st = 0; st < STEPS; st++) begin
         row = (p * STRIPS + s) * STEPS + st;
         if (!hold_known[row]) return n;
         for (int b = 0; b < BULBS; b++)
            if (!lamp_known[row * BULBS + b]) return n;
         n++;
      end
      return n;
   endfunction

   // Gap length in cycles: mostly none or short, now and then long.
   function automatic int idle_len();
      int r;
      if (calm) return 0;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 85) return $urandom_range(1, 3);
      if (r < 97) return $urandom_range(4, 12);
      return $urandom_range(20, 60);
   endfunction

   function automatic req_word_type noise_word();
      logic [127:0] bits;
      bits = {$urandom(), $urandom(), $urandom(), $urandom()};
      return bits[$bits(req_word_type)-1:0];
   endfunction

   function automatic logic [COLOR_W-1:0] pick_color();
      case ($urandom_range(0, 9))
         0:       return '0;
         1:       return '1;
         default: return COLOR_W'($urandom());
      endcase
   endfunction

   function automatic logic [DURATION_W-1:0] pick_hold();
      int r;
      r = $urandom_range(0, 99);
      if (r < 75) return DURATION_W'($urandom_range(0, 30));
      if (r < 90) return DURATION_W'($urandom_range(31, 200));
      if (r < 97) return DURATION_W'($urandom());
      return (r[0]) ? '1 : '0;
   endfunction

   // Applies one accepted word to the mirror state and queues the bulb updates it causes.
   task automatic animate(input req_word_type w, input logic quiet);
      rsp_word_type fresh [$];
      rsp_word_type r;
      int p, s, b, cnt, slot, row;
      slot = w.table_pattern * STRIPS + w.table_strip;
      row  = slot * STEPS + w.table_step;
      case (w.command)
         CMD_TICK: begin
            p = pattern_for(w.armed, w.flight_mode);
            for (s = 0; s < STRIPS; s++) begin
               cnt = step_total[p * STRIPS + s];
               if (cnt != 0 && w.now_ms >= strip_due[s]) begin
                  strip_step[s] = STEP_W'((strip_step[s] + 1) % cnt);
                  row = (p * STRIPS + s) * STEPS + strip_step[s];
                  strip_due[s] = w.now_ms + hold_ms[row];
                  for (b = 0; b < BULBS; b++) begin
                     r.strip_index = STRIP_W'(s);
                     r.bulb_index  = BULB_W'(b);
                     r.bulb_color  = lamp_color[row * BULBS + b];
                     r.last        = 1'b0;
                     fresh.push_back(r);
                  end
               end
            end
         end
         CMD_COUNT: begin
            step_total[slot] = (w.table_count > STEPS) ? COUNT_W'(STEPS) : w.table_count;
         end
         CMD_DURATION: begin
            hold_ms[row]    = w.table_duration;
            hold_known[row] = 1'b1;
         end
         CMD_COLOR: begin
            lamp_color[row * BULBS + w.table_bulb] = w.table_color;
            lamp_known[row * BULBS + w.table_bulb] = 1'b1;
         end
      endcase
      if (!quiet) begin
         foreach (fresh[i]) begin
            r = fresh[i];
            r.last = (i == fresh.size() - 1);
            updates_due.push_back(r);
         end
      end
   endtask

   // Offers one word after a random gap and waits for it to be taken.
   task automatic offer(input req_word_type w, input logic quiet);
      int gap;
      gap = idle_len();
      @(negedge clock);
      if (gap > 0) begin
         req_chan.valid = 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_chan.command        = w.command;
      req_chan.now_ms         = w.now_ms;
      req_chan.armed          = w.armed;
      req_chan.flight_mode    = w.flight_mode;
      req_chan.table_pattern  = w.table_pattern;
      req_chan.table_strip    = w.table_strip;
      req_chan.table_step     = w.table_step;
      req_chan.table_bulb     = w.table_bulb;
      req_chan.table_color    = w.table_color;
      req_chan.table_duration = w.table_duration;
      req_chan.table_count    = w.table_count;
      req_chan.valid          = 1'b1;
      do @(posedge clock); while (!req_chan.ready);
      animate(w, quiet);
      sent++;
   endtask

   task automatic pause_until_drained();
      @(negedge clock);
      req_chan.valid = 1'b0;
      while (updates_due.size() != 0) @(posedge clock);
   endtask

   // Writes every bulb and the duration of steps 0..n-1, then the step count.
   task automatic load_pattern(input int p, input int s, input int n);
      req_word_type w;
      for (int st = 0; st < n; st++) begin
         for (int b = 0; b < BULBS; b++) begin
            w = noise_word();
            w.command       = CMD_COLOR;
            w.table_pattern = PATTERN_W'(p);
            w.table_strip   = STRIP_W'(s);
            w.table_step    = STEP_W'(st);
            w.table_bulb    = BULB_W'(b);
            w.table_color   = pick_color();
            offer(w, 1'b0);
         end
         w = noise_word();
         w.command        = CMD_DURATION;
         w.table_pattern  = PATTERN_W'(p);
         w.table_strip    = STRIP_W'(s);
         w.table_step     = STEP_W'(st);
         w.table_duration = pick_hold();
         offer(w, 1'b0);
      end
      w = noise_word();
      w.command       = CMD_COUNT;
      w.table_pattern = PATTERN_W'(p);
      w.table_strip   = STRIP_W'(s);
      if (n == STEPS)
         w.table_count = COUNT_W'($urandom_range(STEPS, COUNT_MAX));
      else if ($urandom_range(0, 9) == 0)
         w.table_count = COUNT_W'($urandom_range(0, n));
      else
         w.table_count = COUNT_W'(n);
      offer(w, 1'b0);
      if (w.table_count != 0) loaded_pats.push_back(PATTERN_W'(p));
   endtask

   // Time mostly moves forward a little; now and then it jumps.
   task automatic send_tick();
      req_word_type w;
      w = noise_word();
      w.command = CMD_TICK;
      if ($urandom_range(0, 29) == 0)
         wall_ms = ($urandom_range(0, 1) == 0) ? TIME_W'($urandom()) : wall_ms + 70000;
      else
         wall_ms = wall_ms + $urandom_range(0, 40);
      w.now_ms = wall_ms;
      if (loaded_pats.size() != 0 && $urandom_range(0, 3) != 0)
         aim_at(loaded_pats[$urandom_range(0, loaded_pats.size() - 1)], w);
      offer(w, 1'b0);
   endtask

   // A lone table write anywhere; a count never reaches past the written steps.
   task automatic send_stray_write();
      req_word_type w;
      int have;
      w = noise_word();
      w.command = command_type'($urandom_range(CMD_COLOR, CMD_COUNT));
      if (w.command == CMD_COUNT) begin
         have = ready_steps(w.table_pattern, w.table_strip);
         if (have < STEPS) w.table_count = COUNT_W'($urandom_range(0, have));
      end
      offer(w, 1'b0);
   endtask

   task automatic compare_field(input string name, input logic [31:0] want,
                                input logic [31:0] got);
      if (want !== got) begin
         $display("%0t: %s expected %0h actual %0h", $time, name, want, got);
         mismatches++;
      end
   endtask

   // Stimulus: opening script, random traffic, then drain.
   initial begin
      int p;
      int pick;
      logic paused_once;
      paused_once = 1'b0;
      foreach (lamp_known[i]) lamp_known[i] = 1'b0;
      foreach (hold_known[i]) hold_known[i] = 1'b0;
      foreach (step_total[i]) step_total[i] = '0;
      foreach (strip_step[i]) strip_step[i] = '0;
      foreach (strip_due[i]) strip_due[i] = '0;
      req_chan.valid          = 1'b0;
      req_chan.command        = '0;
      req_chan.now_ms         = '0;
      req_chan.armed          = 1'b0;
      req_chan.flight_mode    = '0;
      req_chan.table_pattern  = '0;
      req_chan.table_strip    = '0;
      req_chan.table_step     = '0;
      req_chan.table_bulb     = '0;
      req_chan.table_color    = '0;
      req_chan.table_duration = '0;
      req_chan.table_count    = '0;
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      foreach (SCRIPT[i]) offer(SCRIPT[i].word, SCRIPT[i].quiet);

      // Start with one full-length pattern so that saturated counts get played back.
      sent = 0;
      load_pattern(SHOWN[$urandom_range(0, 7)], $urandom_range(0, STRIPS - 1), STEPS);
      while (sent < RANDOM_ITEMS) begin
         if ($urandom_range(0, 9) == 0) calm = !calm;
         if (!paused_once && sent >= RANDOM_ITEMS / 2) begin
            pause_until_drained();
            paused_once = 1'b1;
         end
         pick = $urandom_range(0, 99);
         if (pick < 12) begin
            p = ($urandom_range(0, 9) < 8) ? SHOWN[$urandom_range(0, 7)]
                                           : $urandom_range(0, PATTERNS - 1);
            load_pattern(p, $urandom_range(0, STRIPS - 1),
                         ($urandom_range(0, 19) == 0) ? STEPS : $urandom_range(1, 3));
         end else if (pick < 85) begin
            send_tick();
         end else begin
            send_stray_write();
         end
      end

      pause_until_drained();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatches == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

   // Result side: random stalls, plus one long hold-off to back the block up.
   initial begin
      int stall_left;
      stall_left = 0;
      rsp_chan.ready = 1'b0;
      wait (!reset);
      forever begin
         @(negedge clock);
         if (!long_hold_done && words_checked >= 60) begin
            long_hold_done = 1'b1;
            stall_left = LONG_HOLD;
         end else if (stall_left == 0 && !calm && $urandom_range(0, 3) == 0) begin
            stall_left = idle_len();
         end
         if (stall_left > 0) begin
            rsp_chan.ready = 1'b0;
            stall_left--;
         end else begin
            rsp_chan.ready = 1'b1;
         end
      end
   end

   // Each bulb update must match the oldest one still owed.
   always @(posedge clock) begin
      rsp_word_type want;
      if (!reset && rsp_chan.valid && rsp_chan.ready) begin
         words_checked++;
         if (updates_due.size() == 0) begin
            $display("%0t: expected no word, actual strip %0h bulb %0h color %0h last %0h",
                     $time, rsp_chan.strip_index, rsp_chan.bulb_index,
                     rsp_chan.bulb_color, rsp_chan.last);
            mismatches++;
         end else begin
            want = updates_due.pop_front();
            compare_field("strip_index", want.strip_index, rsp_chan.strip_index);
            compare_field("bulb_index", want.bulb_index, rsp_chan.bulb_index);
            compare_field("bulb_color", want.bulb_color, rsp_chan.bulb_color);
            compare_field("last", want.last, rsp_chan.last);
         end
      end
   end

   // Watchdog.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("Some tests failed");
         $finish;
      end
   end

endmodule

### filelist.f
hw/rtl/lps_pkg.sv
hw/rtl/lps_ifs.sv
hw/rtl/lps_ram.sv
hw/rtl/lps_ctrl.sv
hw/rtl/lps_dp.sv
hw/rtl/led_pattern_sequencer.sv
test/tb.sv
